FILE: hw/rtl/hed_pkg.sv
// Shared types, character codes and entity tables for the HTML entity decoder.
`timescale 1ns / 1ps

package hed_pkg;

  localparam int unsigned NodeCount = 23;
  localparam int unsigned QDepth    = 4;

  typedef logic [4:0] node_t;
  typedef logic [2:0] idx_t;

  localparam node_t NODE_IDLE = 5'd0;
  localparam node_t NODE_AMP  = 5'd1;

  localparam logic [7:0] CH_AMP   = 8'h26;  // &
  localparam logic [7:0] CH_QUOT  = 8'h22;  // "
  localparam logic [7:0] CH_APOS  = 8'h27;  // '
  localparam logic [7:0] CH_LT    = 8'h3C;  // <
  localparam logic [7:0] CH_GT    = 8'h3E;  // >
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_SEMI  = 8'h3B;  // ;
  localparam logic [7:0] CH_HASH  = 8'h23;  // #
  localparam logic [7:0] CH_0     = 8'h30;
  localparam logic [7:0] CH_3     = 8'h33;
  localparam logic [7:0] CH_9     = 8'h39;
  localparam logic [7:0] CH_A     = 8'h61;
  localparam logic [7:0] CH_B     = 8'h62;
  localparam logic [7:0] CH_G     = 8'h67;
  localparam logic [7:0] CH_L     = 8'h6C;
  localparam logic [7:0] CH_M     = 8'h6D;
  localparam logic [7:0] CH_N     = 8'h6E;
  localparam logic [7:0] CH_O     = 8'h6F;
  localparam logic [7:0] CH_P     = 8'h70;
  localparam logic [7:0] CH_Q     = 8'h71;
  localparam logic [7:0] CH_S     = 8'h73;
  localparam logic [7:0] CH_T     = 8'h74;
  localparam logic [7:0] CH_U     = 8'h75;

  typedef enum logic [1:0] {
    MATCH_MISS,
    MATCH_EXT,
    MATCH_FULL
  } match_e;

  typedef struct packed {
    match_e     kind;
    node_t      nxt;
    logic [7:0] ent;
  } trans_t;

  // One queued command: pending prefix text of node, then an optional tail byte.
  typedef struct packed {
    node_t      node;
    logic       tail_en;
    logic [7:0] tail;
    logic       last;
  } cmd_t;

  function automatic idx_t node_len(node_t node);
    idx_t len;
    case (node)
      5'd0:                      len = 3'd0;
      5'd1:                      len = 3'd1;
      5'd2, 5'd5, 5'd9, 5'd15,
      5'd17, 5'd19:              len = 3'd2;
      5'd3, 5'd6, 5'd10, 5'd12,
      5'd16, 5'd18, 5'd20:       len = 3'd3;
      5'd4, 5'd7, 5'd11, 5'd13,
      5'd21:                     len = 3'd4;
      5'd8, 5'd14, 5'd22:        len = 3'd5;
      default:                   len = 3'd0;
    endcase
    return len;
  endfunction

  // Byte idx of the held text for a node; only called with idx below node_len.
  function automatic logic [7:0] node_char(node_t node, idx_t idx);
    logic [7:0] ch;
    ch = CH_AMP;
    case (idx)
      3'd0: ch = CH_AMP;
      3'd1: begin
        case (node)
          5'd2, 5'd3, 5'd4:                       ch = CH_A;
          5'd5, 5'd6, 5'd7, 5'd8:                 ch = CH_Q;
          5'd9, 5'd10, 5'd11, 5'd12, 5'd13, 5'd14: ch = CH_HASH;
          5'd15, 5'd16:                           ch = CH_L;
          5'd17, 5'd18:                           ch = CH_G;
          default:                                ch = CH_N;
        endcase
      end
      3'd2: begin
        case (node)
          5'd3, 5'd4:          ch = CH_M;
          5'd6, 5'd7, 5'd8:    ch = CH_U;
          5'd10, 5'd11:        ch = CH_3;
          5'd12, 5'd13, 5'd14: ch = CH_0;
          5'd16, 5'd18:        ch = CH_T;
          default:             ch = CH_B;
        endcase
      end
      3'd3: begin
        case (node)
          5'd4:         ch = CH_P;
          5'd7, 5'd8:   ch = CH_O;
          5'd11:        ch = CH_9;
          5'd13, 5'd14: ch = CH_3;
          default:      ch = CH_S;
        endcase
      end
      3'd4: begin
        case (node)
          5'd8:    ch = CH_T;
          5'd14:   ch = CH_9;
          default: ch = CH_P;
        endcase
      end
      default: ch = CH_AMP;
    endcase
    return ch;
  endfunction

  function automatic trans_t ext(node_t nxt);
    trans_t t;
    t.kind = MATCH_EXT;
    t.nxt  = nxt;
    t.ent  = 8'h00;
    return t;
  endfunction

  function automatic trans_t full(logic [7:0] ent);
    trans_t t;
    t.kind = MATCH_FULL;
    t.nxt  = NODE_IDLE;
    t.ent  = ent;
    return t;
  endfunction

  // Step the prefix trie by one byte.
  function automatic trans_t step(node_t node, logic [7:0] c);
    trans_t t;
    t.kind = MATCH_MISS;
    t.nxt  = NODE_IDLE;
    t.ent  = 8'h00;
    case (node)
      5'd0:  if (c == CH_AMP) t = ext(NODE_AMP);
      5'd1: begin
        if (c == CH_A)         t = ext(5'd2);
        else if (c == CH_Q)    t = ext(5'd5);
        else if (c == CH_HASH) t = ext(5'd9);
        else if (c == CH_L)    t = ext(5'd15);
        else if (c == CH_G)    t = ext(5'd17);
        else if (c == CH_N)    t = ext(5'd19);
      end
      5'd2:  if (c == CH_M)    t = ext(5'd3);
      5'd3:  if (c == CH_P)    t = ext(5'd4);
      5'd4:  if (c == CH_SEMI) t = full(CH_AMP);
      5'd5:  if (c == CH_U)    t = ext(5'd6);
      5'd6:  if (c == CH_O)    t = ext(5'd7);
      5'd7:  if (c == CH_T)    t = ext(5'd8);
      5'd8:  if (c == CH_SEMI) t = full(CH_QUOT);
      5'd9: begin
        if (c == CH_3)      t = ext(5'd10);
        else if (c == CH_0) t = ext(5'd12);
      end
      5'd10: if (c == CH_9)    t = ext(5'd11);
      5'd11: if (c == CH_SEMI) t = full(CH_APOS);
      5'd12: if (c == CH_3)    t = ext(5'd13);
      5'd13: if (c == CH_9)    t = ext(5'd14);
      5'd14: if (c == CH_SEMI) t = full(CH_APOS);
      5'd15: if (c == CH_T)    t = ext(5'd16);
      5'd16: if (c == CH_SEMI) t = full(CH_LT);
      5'd17: if (c == CH_T)    t = ext(5'd18);
      5'd18: if (c == CH_SEMI) t = full(CH_GT);
      5'd19: if (c == CH_B)    t = ext(5'd20);
      5'd20: if (c == CH_S)    t = ext(5'd21);
      5'd21: if (c == CH_P)    t = ext(5'd22);
      5'd22: if (c == CH_SEMI) t = full(CH_SPACE);
      default: t.kind = MATCH_MISS;
    endcase
    return t;
  endfunction

endpackage

FILE: hw/rtl/hed_front.sv
// Front end: tracks the entity prefix and turns each accepted input word into at most one command.
`timescale 1ns / 1ps

module hed_front (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          accept_i,
  input  logic [7:0]    in_char_i,
  input  logic          in_last_i,
  output logic          push_o,
  output hed_pkg::cmd_t cmd_o
);

  hed_pkg::node_t  node_q, node_d;
  hed_pkg::node_t  cur;
  hed_pkg::trans_t tr;

  always_comb begin
    // Unused node codes behave as idle.
    cur = (node_q >= 5'(hed_pkg::NodeCount)) ? hed_pkg::NODE_IDLE : node_q;
    tr  = hed_pkg::step(cur, in_char_i);

    cmd_o.node    = cur;
    cmd_o.tail_en = 1'b1;
    cmd_o.tail    = in_char_i;
    cmd_o.last    = in_last_i;
    node_d        = hed_pkg::NODE_IDLE;

    case (tr.kind)
      hed_pkg::MATCH_FULL: begin
        cmd_o.node = hed_pkg::NODE_IDLE;
        cmd_o.tail = tr.ent;
      end
      hed_pkg::MATCH_EXT: begin
        // Hold the prefix; a string end flushes it literally.
        node_d = in_last_i ? hed_pkg::NODE_IDLE : tr.nxt;
        cmd_o.tail_en = in_last_i;
        if (!in_last_i) begin
          cmd_o.node = hed_pkg::NODE_IDLE;
        end
      end
      default: begin
        if (in_char_i == hed_pkg::CH_AMP) begin
          // Restart matching at the new ampersand.
          node_d = in_last_i ? hed_pkg::NODE_IDLE : hed_pkg::NODE_AMP;
          cmd_o.tail_en = in_last_i;
        end
      end
    endcase

    push_o = accept_i && (cmd_o.tail_en || (hed_pkg::node_len(cmd_o.node) != 3'd0));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      node_q <= hed_pkg::NODE_IDLE;
    end else if (accept_i) begin
      node_q <= node_d;
    end
  end

endmodule

FILE: hw/rtl/hed_queue.sv
// Short command queue between the classifier and the byte expander.
`timescale 1ns / 1ps

module hed_queue (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  hed_pkg::cmd_t cmd_i,
  input  logic          pop_i,
  output logic          full_o,
  output logic          empty_o,
  output hed_pkg::cmd_t head_o
);

  localparam int unsigned PtrW = $clog2(hed_pkg::QDepth);
  localparam int unsigned CntW = $clog2(hed_pkg::QDepth + 1);

  hed_pkg::cmd_t   mem_q [hed_pkg::QDepth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] count_q;

  assign full_o  = (count_q == CntW'(hed_pkg::QDepth));
  assign empty_o = (count_q == '0);
  assign head_o  = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= cmd_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) wr_ptr_q <= wr_ptr_q + PtrW'(1);
      if (pop_i)  rd_ptr_q <= rd_ptr_q + PtrW'(1);
      if (push_i && !pop_i)      count_q <= count_q + CntW'(1);
      else if (pop_i && !push_i) count_q <= count_q - CntW'(1);
    end
  end

  a_no_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    full_o |-> !push_i) else $error("push into full queue");
  a_no_pop_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    empty_o |-> !pop_i) else $error("pop from empty queue");

endmodule

FILE: hw/rtl/hed_back.sv
// Back end: expands queued commands into output bytes, one per cycle unless out_stall_i is set.
`timescale 1ns / 1ps

module hed_back (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          empty_i,
  input  hed_pkg::cmd_t head_i,
  output logic          pop_o,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  output logic [7:0]    out_char_o,
  output logic          run_last_o,
  output logic          str_end_o
);

  hed_pkg::idx_t idx_q, idx_d;
  hed_pkg::idx_t plen, total;
  logic          advance, final_byte;
  logic          valid_q;
  logic [7:0]    char_q, char_d;
  logic          run_last_q, str_end_q;

  always_comb begin
    plen       = hed_pkg::node_len(head_i.node);
    total      = plen + {2'b00, head_i.tail_en};
    final_byte = (idx_q == total - 3'd1);
    char_d     = (idx_q < plen) ? hed_pkg::node_char(head_i.node, idx_q) : head_i.tail;
    advance    = !empty_i && (!valid_q || !out_stall_i);
    pop_o      = advance && final_byte;
    idx_d      = final_byte ? 3'd0 : idx_q + 3'd1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      idx_q   <= 3'd0;
    end else if (advance) begin
      valid_q <= 1'b1;
      idx_q   <= idx_d;
    end else if (!out_stall_i) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      char_q     <= char_d;
      run_last_q <= final_byte;
      str_end_q  <= final_byte && head_i.last;
    end
  end

  assign out_valid_o = valid_q;
  assign out_char_o  = char_q;
  assign run_last_o  = run_last_q;
  assign str_end_o   = str_end_q;

  a_idx_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty_i |-> (idx_q < total)) else $error("byte index past command length");
  a_idx_rest: assert property (@(posedge clk_i) disable iff (!rst_ni)
    empty_i |-> (idx_q == 3'd0)) else $error("byte index left mid-command");

endmodule

FILE: hw/rtl/html_entity_decoder_core.sv
// Top level of the streaming HTML entity decoder.
`timescale 1ns / 1ps

// Takes one text byte per cycle and decodes &amp; &quot; &#39; &#039; &lt; &gt;
// and &nbsp; into single bytes; other bytes pass through. A partial entity is
// held with no output until it completes or breaks; a break emits the held
// bytes literally, and in_last_i flushes any held prefix. Each input word
// makes zero to six output words; run_last_o marks the last of them and
// str_end_o also marks the final word of a string. The classifier accepts
// one word per cycle while the four-entry command queue has room; the
// expander drains one output byte per cycle unless out_stall_i is set, so
// literal flushes of up to six bytes back up into the queue and stall the
// input only when it fills.

module html_entity_decoder_core (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] in_char_i,
  input  logic       in_last_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [7:0] out_char_o,
  output logic       run_last_o,
  output logic       str_end_o
);

  logic          accept, push, pop, full, empty;
  hed_pkg::cmd_t cmd, head;

  assign in_stall_o = full;
  assign accept     = in_valid_i && !full;

  hed_front u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .accept_i  (accept),
    .in_char_i (in_char_i),
    .in_last_i (in_last_i),
    .push_o    (push),
    .cmd_o     (cmd)
  );

  hed_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .cmd_i   (cmd),
    .pop_i   (pop),
    .full_o  (full),
    .empty_o (empty),
    .head_o  (head)
  );

  hed_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .empty_i     (empty),
    .head_i      (head),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_char_o  (out_char_o),
    .run_last_o  (run_last_o),
    .str_end_o   (str_end_o)
  );

endmodule

FILE: verif/tb_top.sv
// Self-checking testbench for the streaming HTML entity decoder core.
`timescale 1ns / 1ps

module tb_top;

  localparam int CycleLimit = 100000;
  localparam int ItemTarget = 450;
  localparam int IdlePct    = 8;

  typedef struct packed {
    logic [7:0] ch;
    logic       last;
  } text_byte_t;

  typedef struct packed {
    logic [7:0] ch;
    logic       run_last;
    logic       str_end;
  } out_word_t;

  logic       clk_i      = 1'b0;
  logic       rst_ni     = 1'b0;
  logic       in_valid   = 1'b0;
  logic [7:0] in_char    = 8'h00;
  logic       in_last    = 1'b0;
  logic       out_stall  = 1'b0;
  logic       in_stall;
  logic       out_valid;
  logic [7:0] out_char;
  logic       run_last;
  logic       str_end;

  text_byte_t text_q[$];
  out_word_t  decoded_q[$];
  logic [7:0] held_q[$];
  logic [7:0] cand_q[$];
  out_word_t  got_word;
  out_word_t  want_word;
  text_byte_t next_byte;
  int         sent_cnt   = 0;
  int         err_cnt    = 0;
  int         cycle_cnt  = 0;
  bit         drain_hold = 1'b0;
  bit         quiet;

  string      ent_text [7] = '{"&amp;", "&quot;", "&#39;", "&#039;", "&lt;", "&gt;", "&nbsp;"};
  logic [7:0] ent_char [7] = '{hed_pkg::CH_AMP, hed_pkg::CH_QUOT, hed_pkg::CH_APOS,
                               hed_pkg::CH_APOS, hed_pkg::CH_LT, hed_pkg::CH_GT,
                               hed_pkg::CH_SPACE};
  string      ent_alpha    = "&#039;abglmnopqstu";

  html_entity_decoder_core u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall),
    .in_char_i  (in_char),
    .in_last_i  (in_last),
    .out_valid_o(out_valid),
    .out_stall_i(out_stall),
    .out_char_o (out_char),
    .run_last_o (run_last),
    .str_end_o  (str_end)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // Middle stretch of the run with no idling on either side.
  assign quiet = (sent_cnt >= 120) && (sent_cnt < 240);

  task automatic report_mismatch(input string msg);
    $display("mismatch @%0t: %s", $time, msg);
    err_cnt++;
  endtask

  // Whole: candidate equals s. Otherwise: candidate is a proper prefix of s.
  function automatic bit cand_is(input string s, input bit whole);
    if (whole ? (cand_q.size() != s.len()) : (cand_q.size() >= s.len())) return 1'b0;
    foreach (cand_q[i]) begin
      if (cand_q[i] != 8'(s.getc(i))) return 1'b0;
    end
    return 1'b1;
  endfunction

  task automatic decode_byte(input logic [7:0] c, input logic last);
    logic [7:0] outs[$];
    out_word_t  w;
    bit         done;
    done   = 1'b0;
    cand_q = held_q;
    cand_q.push_back(c);
    for (int k = 0; k < 7 && !done; k++) begin
      if (cand_is(ent_text[k], 1'b1)) begin
        outs.push_back(ent_char[k]);
        held_q.delete();
        done = 1'b1;
      end
    end
    for (int k = 0; k < 7 && !done; k++) begin
      if (cand_is(ent_text[k], 1'b0)) begin
        held_q = cand_q;
        done   = 1'b1;
      end
    end
    if (!done) begin
      // Broken prefix: emit held bytes literally, then restart on this byte.
      foreach (held_q[i]) outs.push_back(held_q[i]);
      held_q.delete();
      if (c == hed_pkg::CH_AMP) held_q.push_back(hed_pkg::CH_AMP);
      else outs.push_back(c);
    end
    if (last) begin
      foreach (held_q[i]) outs.push_back(held_q[i]);
      held_q.delete();
    end
    foreach (outs[i]) begin
      w.ch       = outs[i];
      w.run_last = (i == outs.size() - 1);
      w.str_end  = last && (i == outs.size() - 1);
      decoded_q.push_back(w);
    end
  endtask

  task automatic add_byte(input logic [7:0] c, input logic last);
    text_byte_t b;
    b.ch   = c;
    b.last = last;
    text_q.push_back(b);
  endtask

  task automatic add_text(input string s, input bit last_at_end);
    for (int i = 0; i < s.len(); i++) begin
      add_byte(8'(s.getc(i)), last_at_end && (i == s.len() - 1));
    end
  endtask

  // Mostly entities and their prefixes, with random bytes mixed in.
  task automatic add_random_text();
    logic [7:0] body[$];
    string      e;
    int         nseg;
    int         pick;
    int         cut;
    nseg = $urandom_range(1, 5);
    repeat (nseg) begin
      pick = $urandom_range(9);
      e    = ent_text[$urandom_range(6)];
      if (pick <= 3) begin
        for (int j = 0; j < e.len(); j++) body.push_back(8'(e.getc(j)));
      end else if (pick <= 5) begin
        cut = $urandom_range(1, e.len() - 1);
        for (int j = 0; j < cut; j++) body.push_back(8'(e.getc(j)));
      end else if (pick <= 7) begin
        body.push_back(8'($urandom_range(255)));
      end else if (pick == 8) begin
        body.push_back(hed_pkg::CH_AMP);
      end else begin
        body.push_back(8'(ent_alpha.getc($urandom_range(ent_alpha.len() - 1))));
      end
    end
    foreach (body[i]) add_byte(body[i], i == body.size() - 1);
  endtask

  // Sender
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid <= 1'b0;
      in_char  <= 8'h00;
      in_last  <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        decode_byte(in_char, in_last);
        sent_cnt++;
        if (sent_cnt == 60 || sent_cnt == 300) drain_hold = 1'b1;
      end
      if (!in_valid || !in_stall) begin
        if (drain_hold && decoded_q.size() == 0) drain_hold = 1'b0;
        if (text_q.size() != 0 && !drain_hold && (quiet || $urandom_range(99) >= IdlePct)) begin
          next_byte = text_q.pop_front();
          in_valid <= 1'b1;
          in_char  <= next_byte.ch;
          in_last  <= next_byte.last;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Receiver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        got_word = '{ch: out_char, run_last: run_last, str_end: str_end};
        if (decoded_q.size() == 0) begin
          report_mismatch($sformatf("unexpected word char=%02h run_last=%b str_end=%b",
                                    out_char, run_last, str_end));
        end else begin
          want_word = decoded_q.pop_front();
          if (got_word.ch != want_word.ch)
            report_mismatch($sformatf("out_char %02h, want %02h", got_word.ch, want_word.ch));
          if (got_word.run_last != want_word.run_last)
            report_mismatch($sformatf("run_last %b, want %b",
                                      got_word.run_last, want_word.run_last));
          if (got_word.str_end != want_word.str_end)
            report_mismatch($sformatf("str_end %b, want %b",
                                      got_word.str_end, want_word.str_end));
        end
      end
      out_stall <= !quiet && ($urandom_range(99) < IdlePct);
    end
  end

  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt == CycleLimit) begin
      $display("timeout after %0d cycles", cycle_cnt);
      $display("tb_top failed");
      $finish;
    end
  end

  initial begin
    // Full match, broken prefix before 0xFF, longest flush before a zero byte.
    add_text("&lt;", 1'b0);
    add_text("&#3", 1'b0);
    add_byte(8'hFF, 1'b0);
    add_text("&quot", 1'b0);
    add_byte(8'h00, 1'b0);
    add_text("&amp;", 1'b0);
    // Unfinished prefix flushed at end of string, then a one-byte string.
    add_text("&nbs", 1'b1);
    add_byte(8'h01, 1'b1);
    while (text_q.size() < ItemTarget) add_random_text();

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    while (text_q.size() != 0 || in_valid || decoded_q.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (err_cnt == 0) begin
      $display("tb_top passed");
    end else begin
      $display("tb_top failed");
    end
    $finish;
  end

endmodule

FILE: html_entity_decoder_core.f
hw/rtl/hed_pkg.sv
hw/rtl/hed_front.sv
hw/rtl/hed_queue.sv
hw/rtl/hed_back.sv
hw/rtl/html_entity_decoder_core.sv
verif/tb_top.sv
